// ----- design/x86ex_pkg.sv -----
package x86ex_pkg;

  localparam int IDX_W  = 4;
  localparam int DATA_W = 16;
  localparam int BYTE_W = 8;

  localparam logic [2:0] MODE_MOV = 3'd0;
  localparam logic [2:0] MODE_ADD = 3'd1;
  localparam logic [2:0] MODE_SUB = 3'd2;
  localparam logic [2:0] MODE_CMP = 3'd3;

  localparam logic [1:0] SRC_IMM = 2'd1;
  localparam logic [1:0] SRC_REG = 2'd2;

  typedef struct packed {
    logic [2:0]        mode;
    logic              dest_is_register;
    logic [IDX_W-1:0]  dest_index;
    logic              dest_wide;
    logic              dest_high_byte;
    logic [1:0]        src_kind;
    logic [IDX_W-1:0]  src_index;
    logic              src_wide;
    logic              src_high_byte;
    logic signed [DATA_W-1:0] immediate;
  } in_item_t;

  typedef struct packed {
    logic              reg_written;
    logic [IDX_W-1:0]  written_index;
    logic [DATA_W-1:0] old_value;
    logic [DATA_W-1:0] new_value;
    logic              zero_flag;
    logic              sign_flag;
    logic              flags_changed;
  } out_item_t;

  typedef struct packed {
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [DATA_W-1:0] wr_data;
  } rf_wr_t;

endpackage

// ----- design/x86ex_rf.sv -----
module x86ex_rf import x86ex_pkg::*; #(
  parameter int REG_COUNT = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [IDX_W-1:0]  rd_addr_a,
  input  logic [IDX_W-1:0]  rd_addr_b,
  input  rf_wr_t            wr,
  output logic [DATA_W-1:0] rd_data_a,
  output logic [DATA_W-1:0] rd_data_b
);

  localparam int AW = $clog2(REG_COUNT);

  logic [DATA_W-1:0]    mem [REG_COUNT];
  logic [REG_COUNT-1:0] vld;

  logic [DATA_W-1:0] q_a;
  logic [DATA_W-1:0] q_b;
  logic              ok_a;
  logic              ok_b;
  logic [IDX_W-1:0]  addr_a;
  logic [IDX_W-1:0]  addr_b;

  logic              lw_valid;
  logic [IDX_W-1:0]  lw_addr;
  logic [DATA_W-1:0] lw_data;

  logic in_range_a;
  logic in_range_b;

  assign in_range_a = int'(rd_addr_a) < REG_COUNT;
  assign in_range_b = int'(rd_addr_b) < REG_COUNT;

  always_ff @(posedge clk) begin
    if (wr.wr_en) begin
      mem[wr.wr_addr[AW-1:0]] <= wr.wr_data;
    end
    if (rd_en) begin
      addr_a <= rd_addr_a;
      addr_b <= rd_addr_b;
      if (in_range_a) begin
        q_a <= mem[rd_addr_a[AW-1:0]];
      end
      if (in_range_b) begin
        q_b <= mem[rd_addr_b[AW-1:0]];
      end
    end
    if (wr.wr_en) begin
      lw_addr <= wr.wr_addr;
      lw_data <= wr.wr_data;
    end
  end

  // valid bits stand in for clearing the array at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      ok_a     <= 1'b0;
      ok_b     <= 1'b0;
      lw_valid <= 1'b0;
    end else begin
      if (wr.wr_en) begin
        vld[wr.wr_addr[AW-1:0]] <= 1'b1;
        lw_valid                <= 1'b1;
      end
      if (rd_en) begin
        ok_a <= in_range_a && vld[rd_addr_a[AW-1:0]];
        ok_b <= in_range_b && vld[rd_addr_b[AW-1:0]];
      end
    end
  end

  // forward the latest write over a read taken at the same edge
  always_comb begin
    if (lw_valid && lw_addr == addr_a) begin
      rd_data_a = lw_data;
    end else begin
      rd_data_a = ok_a ? q_a : '0;
    end
    if (lw_valid && lw_addr == addr_b) begin
      rd_data_b = lw_data;
    end else begin
      rd_data_b = ok_b ? q_b : '0;
    end
  end

endmodule

// ----- design/x86ex_alu.sv -----
module x86ex_alu import x86ex_pkg::*; #(
  parameter int REG_COUNT = 16
) (
  input  in_item_t          item,
  input  logic [DATA_W-1:0] dword,
  input  logic [DATA_W-1:0] sword,
  input  logic              zf,
  input  logic              sf,
  output out_item_t         res,
  output rf_wr_t            wr
);

  logic [DATA_W-1:0] mask;
  logic [DATA_W-1:0] dval;
  logic [DATA_W-1:0] sval;
  logic [DATA_W-1:0] src;
  logic [DATA_W-1:0] alu;
  logic [DATA_W-1:0] merged;
  logic              active;
  logic              set_flags;
  logic              do_write;
  logic              in_range;
  logic              zf_next;
  logic              sf_next;

  always_comb begin
    mask = item.dest_wide ? {DATA_W{1'b1}} : {{(DATA_W-BYTE_W){1'b0}}, {BYTE_W{1'b1}}};

    if (item.dest_wide) begin
      dval = dword;
    end else if (item.dest_high_byte) begin
      dval = {{(DATA_W-BYTE_W){1'b0}}, dword[DATA_W-1:BYTE_W]};
    end else begin
      dval = {{(DATA_W-BYTE_W){1'b0}}, dword[BYTE_W-1:0]};
    end

    if (item.src_wide) begin
      sval = sword;
    end else if (item.src_high_byte) begin
      sval = {{(DATA_W-BYTE_W){1'b0}}, sword[DATA_W-1:BYTE_W]};
    end else begin
      sval = {{(DATA_W-BYTE_W){1'b0}}, sword[BYTE_W-1:0]};
    end

    unique case (item.src_kind)
      SRC_IMM: src = item.immediate & mask;
      SRC_REG: src = sval & mask;
      default: src = '0;
    endcase

    unique case (item.mode)
      MODE_MOV: alu = src;
      MODE_ADD: alu = (dval + src) & mask;
      default:  alu = (dval - src) & mask;
    endcase

    if (item.dest_wide) begin
      merged = alu;
    end else if (item.dest_high_byte) begin
      merged = {alu[BYTE_W-1:0], dword[BYTE_W-1:0]};
    end else begin
      merged = {dword[DATA_W-1:BYTE_W], alu[BYTE_W-1:0]};
    end

    active    = (item.mode <= MODE_CMP) && item.dest_is_register;
    set_flags = active && (item.mode != MODE_MOV);
    in_range  = int'(item.dest_index) < REG_COUNT;
    do_write  = active && (item.mode <= MODE_SUB) && in_range;

    zf_next = set_flags ? (alu == '0) : zf;
    sf_next = set_flags ? (item.dest_wide ? alu[DATA_W-1] : alu[BYTE_W-1]) : sf;

    res.reg_written   = do_write;
    res.written_index = do_write ? item.dest_index : '0;
    res.old_value     = do_write ? dword : '0;
    res.new_value     = do_write ? merged : '0;
    res.zero_flag     = zf_next;
    res.sign_flag     = sf_next;
    res.flags_changed = (zf_next != zf) || (sf_next != sf);

    wr.wr_en   = do_write;
    wr.wr_addr = item.dest_index;
    wr.wr_data = merged;
  end

endmodule

// ----- design/x86_16bit_mov_add_sub_cmp_executor_top.sv -----
// Executes one decoded mov, add, sub or cmp per transfer against a register
// file held in a synchronous memory with a registered read, plus zero and sign
// flags. An instruction can be taken every cycle unless the output stalls; its
// result passes through the register file read, registered with the instruction,
// then the add/subtract and write-back into the output register. A dependent
// instruction right behind its producer gets the written value by forwarding,
// so no bubble is inserted. Reset clears all registers and flags at once.
module x86_16bit_mov_add_sub_cmp_executor_top import x86ex_pkg::*; #(
  parameter int REG_COUNT = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic              s1_valid;
  in_item_t          s1_item;
  logic              s1_fire;
  logic              zf;
  logic              sf;
  logic [DATA_W-1:0] dword;
  logic [DATA_W-1:0] sword;
  out_item_t         alu_res;
  rf_wr_t            alu_wr;
  rf_wr_t            rf_wr;
  logic              in_xfer;

  assign s1_fire  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_fire;
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    rf_wr       = alu_wr;
    rf_wr.wr_en = alu_wr.wr_en && s1_fire;
  end

  x86ex_rf #(.REG_COUNT(REG_COUNT)) u_rf (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (in_xfer),
    .rd_addr_a (in_data.dest_index),
    .rd_addr_b (in_data.src_index),
    .wr        (rf_wr),
    .rd_data_a (dword),
    .rd_data_b (sword)
  );

  x86ex_alu #(.REG_COUNT(REG_COUNT)) u_alu (
    .item  (s1_item),
    .dword (dword),
    .sword (sword),
    .zf    (zf),
    .sf    (sf),
    .res   (alu_res),
    .wr    (alu_wr)
  );

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item <= in_data;
    end
    if (s1_fire) begin
      out_data <= alu_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      zf        <= 1'b0;
      sf        <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid <= in_valid;
      end
      if (s1_fire) begin
        out_valid <= 1'b1;
        zf        <= alu_res.zero_flag;
        sf        <= alu_res.sign_flag;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- design/x86ex_checker.sv -----
module x86ex_checker import x86ex_pkg::*; #(
  parameter int REG_COUNT = 16
) (
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  logic prev_zf;
  logic prev_sf;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_zf <= 1'b0;
      prev_sf <= 1'b0;
    end else if (out_valid && !out_stall) begin
      prev_zf <= out_data.zero_flag;
      prev_sf <= out_data.sign_flag;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.reg_written |->
      out_data.written_index == '0 && out_data.old_value == '0 && out_data.new_value == '0)
    else $error("result without write carries register data");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.reg_written |-> int'(out_data.written_index) < REG_COUNT)
    else $error("write reported beyond register file");

  a_flags_changed: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall |->
      out_data.flags_changed == ((out_data.zero_flag != prev_zf) ||
                                 (out_data.sign_flag != prev_sf)))
    else $error("flags_changed disagrees with previous transfer");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind x86_16bit_mov_add_sub_cmp_executor_top x86ex_checker #(.REG_COUNT(REG_COUNT)) u_chk (.*);

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import x86ex_pkg::*;

  localparam int NUM_REGS = 16;
  localparam int HOLD_CYCLES = 200;
  localparam int STUCK_LIMIT = 2000;
  localparam int MAX_PRINTS = 40;

  localparam logic [2:0] MODE_NOP = 3'd4;
  localparam logic [2:0] MODE_UNUSED_HI = 3'd7;
  localparam logic [1:0] SRC_NONE = 2'd0;
  localparam logic [1:0] SRC_UNUSED = 2'd3;

  localparam logic [3:0] REG_ZERO = 4'd0;
  localparam logic [3:0] REG_AX = 4'd1;
  localparam logic [3:0] REG_BX = 4'd2;
  localparam logic [3:0] REG_CX = 4'd3;
  localparam logic [3:0] REG_DX = 4'd4;
  localparam logic [3:0] REG_SP = 4'd5;
  localparam logic [3:0] REG_BP = 4'd6;
  localparam logic [3:0] REG_IP = 4'd13;
  localparam logic [3:0] REG_X14 = 4'd14;
  localparam logic [3:0] REG_X15 = 4'd15;

  localparam logic WORD = 1'b1;
  localparam logic BYTE = 1'b0;
  localparam logic LOW = 1'b0;
  localparam logic HIGH = 1'b1;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  x86_16bit_mov_add_sub_cmp_executor_top #(
    .REG_COUNT(NUM_REGS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  in_item_t  pending_instrs[$];
  out_item_t expected_results[$];
  out_item_t predicted;
  out_item_t oldest;

  logic [15:0] shadow_regs [16] = '{default: '0};
  logic        shadow_zf = 1'b0;
  logic        shadow_sf = 1'b0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_go = 1'b0;
  logic hold_done = 1'b0;
  int hold_count = 0;
  int stuck_cycles = 0;

  int errors = 0;
  int n_issued = 0;
  int n_checked = 0;
  int n_writes = 0;
  int n_ignored = 0;
  int n_zero = 0;
  int n_sign = 0;

  function automatic logic [15:0] shadow_read(logic [3:0] idx);
    return (int'(idx) < NUM_REGS) ? shadow_regs[idx] : 16'h0000;
  endfunction

  function automatic logic [15:0] part_of(logic [15:0] word, logic wide, logic high);
    if (wide) return word;
    return high ? {8'h00, word[15:8]} : {8'h00, word[7:0]};
  endfunction

  // executes one instruction on the shadow register file and flags
  function automatic out_item_t execute_instr(in_item_t it);
    out_item_t   r;
    logic [15:0] mask, dword, dval, src, res;
    logic        zf0, sf0;
    r = '0;
    zf0 = shadow_zf;
    sf0 = shadow_sf;
    if (it.mode <= MODE_CMP && it.dest_is_register) begin
      mask = it.dest_wide ? 16'hFFFF : 16'h00FF;
      dword = shadow_read(it.dest_index);
      dval = part_of(dword, it.dest_wide, it.dest_high_byte);
      case (it.src_kind)
        SRC_IMM: src = it.immediate;
        SRC_REG: src = part_of(shadow_read(it.src_index), it.src_wide, it.src_high_byte);
        default: src = 16'h0000;
      endcase
      src = src & mask;
      case (it.mode)
        MODE_MOV: res = src;
        MODE_ADD: res = (dval + src) & mask;
        default:  res = (dval - src) & mask;
      endcase
      if (it.mode != MODE_MOV) begin
        shadow_zf = (res == 16'h0000);
        shadow_sf = it.dest_wide ? res[15] : res[7];
      end
      if (it.mode != MODE_CMP && int'(it.dest_index) < NUM_REGS) begin
        r.reg_written = 1'b1;
        r.written_index = it.dest_index;
        r.old_value = dword;
        if (it.dest_wide) r.new_value = res;
        else if (it.dest_high_byte) r.new_value = {res[7:0], dword[7:0]};
        else r.new_value = {dword[15:8], res[7:0]};
        shadow_regs[it.dest_index] = r.new_value;
      end
    end
    r.zero_flag = shadow_zf;
    r.sign_flag = shadow_sf;
    r.flags_changed = (shadow_zf != zf0) || (shadow_sf != sf0);
    return r;
  endfunction

  function automatic in_item_t instr(logic [2:0] mode, logic dreg, logic [3:0] didx,
                                     logic dwide, logic dhigh, logic [1:0] skind,
                                     logic [3:0] sidx, logic swide, logic shigh,
                                     logic [15:0] imm);
    in_item_t it;
    it.mode = mode;
    it.dest_is_register = dreg;
    it.dest_index = didx;
    it.dest_wide = dwide;
    it.dest_high_byte = dhigh;
    it.src_kind = skind;
    it.src_index = sidx;
    it.src_wide = swide;
    it.src_high_byte = shigh;
    it.immediate = imm;
    return it;
  endfunction

  function automatic logic [3:0] rand_index();
    int pick;
    pick = $urandom_range(99);
    if (pick < 60) return 4'($urandom_range(REG_CX, REG_ZERO));
    if (pick < 90) return 4'($urandom_range(REG_IP, REG_ZERO));
    return 4'($urandom_range(REG_X15, REG_ZERO));
  endfunction

  // mostly well-formed register instructions on a few hot registers
  function automatic in_item_t rand_instr();
    in_item_t    it;
    int          pick;
    logic [15:0] specials [9] = '{16'h0000, 16'h0001, 16'hFFFF, 16'h8000, 16'h7FFF,
                                  16'h0080, 16'h007F, 16'h00FF, 16'hFF00};
    it = '0;
    it.mode = ($urandom_range(99) < 90) ? 3'($urandom_range(MODE_CMP, MODE_MOV))
                                        : 3'($urandom_range(MODE_UNUSED_HI, MODE_NOP));
    it.dest_is_register = ($urandom_range(99) < 94);
    it.dest_index = rand_index();
    it.dest_wide = 1'($urandom_range(1));
    it.dest_high_byte = 1'($urandom_range(1));
    pick = $urandom_range(99);
    if (pick < 45) it.src_kind = SRC_IMM;
    else if (pick < 90) it.src_kind = SRC_REG;
    else if (pick < 95) it.src_kind = SRC_NONE;
    else it.src_kind = SRC_UNUSED;
    it.src_index = ($urandom_range(99) < 15) ? it.dest_index : rand_index();
    it.src_wide = 1'($urandom_range(1));
    it.src_high_byte = 1'($urandom_range(1));
    it.immediate = ($urandom_range(99) < 70) ? 16'($urandom)
                                             : specials[$urandom_range(8)];
    return it;
  endfunction

  task automatic report_mismatch(string field, logic [15:0] got, logic [15:0] want);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("%0t: result %0d %s mismatch: got %h, expected %h",
               $realtime, n_checked, field, got, want);
  endtask

  task automatic check_field(string field, logic [15:0] got, logic [15:0] want);
    if (got !== want) report_mismatch(field, got, want);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        predicted = execute_instr(in_data);
        expected_results.push_back(predicted);
        n_issued++;
        if (!(in_data.mode <= MODE_CMP && in_data.dest_is_register)) n_ignored++;
        if (predicted.reg_written) n_writes++;
        if (predicted.zero_flag) n_zero++;
        if (predicted.sign_flag) n_sign++;
      end
      if (pending_instrs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data <= pending_instrs.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor and receiver stall
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n_checked++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected transfer", 16'(out_data.new_value), 16'h0000);
        end else begin
          oldest = expected_results.pop_front();
          check_field("reg_written", 16'(out_data.reg_written), 16'(oldest.reg_written));
          check_field("written_index", 16'(out_data.written_index),
                      16'(oldest.written_index));
          check_field("old_value", out_data.old_value, oldest.old_value);
          check_field("new_value", out_data.new_value, oldest.new_value);
          check_field("zero_flag", 16'(out_data.zero_flag), 16'(oldest.zero_flag));
          check_field("sign_flag", 16'(out_data.sign_flag), 16'(oldest.sign_flag));
          check_field("flags_changed", 16'(out_data.flags_changed),
                      16'(oldest.flags_changed));
        end
      end
      if (hold_go && !hold_done) begin
        out_stall <= 1'b1;
        if (hold_count == HOLD_CYCLES) hold_done <= 1'b1;
        hold_count <= hold_count + 1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STUCK_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STUCK_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_instrs.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  task automatic run_phase(int count, int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) pending_instrs.push_back(rand_instr());
    wait_drained();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: extremes, wraps, byte halves, ignored cases and the upper registers
    pending_instrs.push_back(instr(MODE_MOV, 1, REG_AX, WORD, LOW, SRC_IMM, REG_ZERO,
                                   WORD, LOW, 16'h8000));
    pending_instrs.push_back(instr(MODE_MOV, 1, REG_BX, WORD, LOW, SRC_IMM, REG_ZERO,
                                   WORD, LOW, 16'h7FFF));
    pending_instrs.push_back(instr(MODE_ADD, 1, REG_AX, WORD, LOW, SRC_REG, REG_BX,
                                   WORD, LOW, 16'h0000));
    pending_instrs.push_back(instr(MODE_ADD, 1, REG_AX, WORD, LOW, SRC_IMM, REG_ZERO,
                                   WORD, LOW, 16'h0001));
    pending_instrs.push_back(instr(MODE_SUB, 1, REG_AX, WORD, LOW, SRC_IMM, REG_ZERO,
                                   WORD, LOW, 16'h0001));
    pending_instrs.push_back(instr(MODE_CMP, 1, REG_BX, WORD, LOW, SRC_IMM, REG_ZERO,
                                   WORD, LOW, 16'h7FFF));
    pending_instrs.push_back(instr(MODE_MOV, 1, REG_CX, BYTE, LOW, SRC_IMM, REG_ZERO,
                                   WORD, LOW, 16'h1234));
    pending_instrs.push_back(instr(MODE_MOV, 1, REG_CX, BYTE, HIGH, SRC_REG, REG_BX,
                                   BYTE, HIGH, 16'h0000));
    pending_instrs.push_back(instr(MODE_ADD, 1, REG_CX, BYTE, LOW, SRC_IMM, REG_ZERO,
                                   WORD, LOW, 16'hFFCC));
    pending_instrs.push_back(instr(MODE_SUB, 1, REG_CX, BYTE, HIGH, SRC_REG, REG_AX,
                                   BYTE, LOW, 16'h0000));
    pending_instrs.push_back(instr(MODE_ADD, 1, REG_DX, WORD, LOW, SRC_REG, REG_CX,
                                   BYTE, HIGH, 16'h0000));
    pending_instrs.push_back(instr(MODE_MOV, 1, REG_ZERO, WORD, LOW, SRC_IMM, REG_ZERO,
                                   WORD, LOW, 16'hFFFF));
    pending_instrs.push_back(instr(MODE_ADD, 1, REG_SP, WORD, LOW, SRC_REG, REG_ZERO,
                                   WORD, LOW, 16'h0000));
    pending_instrs.push_back(instr(MODE_CMP, 1, REG_SP, BYTE, LOW, SRC_REG, REG_SP,
                                   WORD, LOW, 16'h0000));
    pending_instrs.push_back(instr(MODE_NOP, 1, REG_AX, WORD, LOW, SRC_IMM, REG_ZERO,
                                   WORD, LOW, 16'h5A5A));
    pending_instrs.push_back(instr(MODE_UNUSED_HI, 1, REG_AX, WORD, LOW, SRC_IMM,
                                   REG_ZERO, WORD, LOW, 16'hA5A5));
    pending_instrs.push_back(instr(MODE_MOV, 0, REG_AX, WORD, LOW, SRC_IMM, REG_ZERO,
                                   WORD, LOW, 16'h1111));
    pending_instrs.push_back(instr(MODE_ADD, 1, REG_BX, WORD, LOW, SRC_NONE, REG_AX,
                                   WORD, LOW, 16'h2222));
    pending_instrs.push_back(instr(MODE_MOV, 1, REG_BX, WORD, LOW, SRC_UNUSED, REG_AX,
                                   WORD, LOW, 16'h3333));
    pending_instrs.push_back(instr(MODE_MOV, 1, REG_X14, WORD, LOW, SRC_IMM, REG_ZERO,
                                   WORD, LOW, 16'h5555));
    pending_instrs.push_back(instr(MODE_ADD, 1, REG_X15, WORD, LOW, SRC_IMM, REG_ZERO,
                                   WORD, LOW, 16'h8000));
    pending_instrs.push_back(instr(MODE_MOV, 1, REG_IP, WORD, LOW, SRC_IMM, REG_ZERO,
                                   WORD, LOW, 16'hAAAA));
    pending_instrs.push_back(instr(MODE_MOV, 1, REG_IP, WORD, LOW, SRC_IMM, REG_ZERO,
                                   WORD, LOW, 16'hAAAA));
    pending_instrs.push_back(instr(MODE_SUB, 1, REG_IP, BYTE, HIGH, SRC_REG, REG_IP,
                                   BYTE, HIGH, 16'h0000));
    pending_instrs.push_back(instr(MODE_CMP, 1, REG_BP, WORD, LOW, SRC_IMM, REG_X14,
                                   WORD, LOW, 16'h0000));
    wait_drained();

    run_phase(290, 0, 0);
    run_phase(290, 51, 0);
    run_phase(290, 0, 51);
    run_phase(220, 17, 17);

    // receiver holds off while the sender keeps offering
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_go = 1'b1;
    repeat (60) pending_instrs.push_back(rand_instr());
    do @(negedge clk);
    while (!hold_done);
    wait_drained();

    repeat (8) @(posedge clk);
    $display("ran %0d instructions (%0d ignored), checked %0d results, %0d register writes",
             n_issued, n_ignored, n_checked, n_writes);
    $display("zero flag seen set %0d times, sign flag %0d times, %0d mismatches",
             n_zero, n_sign, errors);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/x86ex_pkg.sv
design/x86ex_rf.sv
design/x86ex_alu.sv
design/x86_16bit_mov_add_sub_cmp_executor_top.sv
design/x86ex_checker.sv
test/testbench.sv
